/* hdl/jsv_pkg.sv */
// package for the json syntax validator: codes, types and constants
package jsv_pkg;

    localparam int MAX_NESTING = 64;
    localparam int DEPTH_W = $clog2(MAX_NESTING + 1);
    localparam int STACK_AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    typedef enum logic [4:0] {
        S_VALUE        = 5'd0,
        S_VAL_OR_CLOSE = 5'd1,
        S_KEY_OR_CLOSE = 5'd2,
        S_KEY          = 5'd3,
        S_COLON        = 5'd4,
        S_AFTER        = 5'd5,
        S_STR_VAL      = 5'd6,
        S_STR_KEY      = 5'd7,
        S_ESC_VAL      = 5'd8,
        S_ESC_KEY      = 5'd9,
        S_HEX_VAL      = 5'd10,
        S_HEX_KEY      = 5'd11,
        S_LIT          = 5'd12,
        S_N_MINUS      = 5'd13,
        S_N_ZERO       = 5'd14,
        S_N_INT        = 5'd15,
        S_N_DOT        = 5'd16,
        S_N_FRAC       = 5'd17,
        S_N_EXP        = 5'd18,
        S_N_ESIGN      = 5'd19,
        S_N_EDIG       = 5'd20
    } parse_state_t;

    typedef enum logic [1:0] {
        LIT_TRUE  = 2'd0,
        LIT_FALSE = 2'd1,
        LIT_NULL  = 2'd2,
        LIT_NONE  = 2'd3
    } lit_kind_t;

    // classified word from the front to the back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       utf8_bad;
        logic       utf8_open;
        logic       is_ws;
        logic       is_digit;
        logic       is_hex;
    } word_t;

    function automatic logic [7:0] lit_char(lit_kind_t kind, logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (kind)
            LIT_TRUE: begin
                case (pos)
                    3'd0: c = "t";
                    3'd1: c = "r";
                    3'd2: c = "u";
                    3'd3: c = "e";
                    default: c = 8'h00;
                endcase
            end
            LIT_FALSE: begin
                case (pos)
                    3'd0: c = "f";
                    3'd1: c = "a";
                    3'd2: c = "l";
                    3'd3: c = "s";
                    3'd4: c = "e";
                    default: c = 8'h00;
                endcase
            end
            LIT_NULL: begin
                case (pos)
                    3'd0: c = "n";
                    3'd1: c = "u";
                    3'd2: c = "l";
                    3'd3: c = "l";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lit_len(lit_kind_t kind);
        logic [2:0] n;
        case (kind)
            LIT_TRUE:  n = 3'd4;
            LIT_FALSE: n = 3'd5;
            LIT_NULL:  n = 3'd4;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

/* hdl/jsv_front.sv */
// front end: utf-8 check and byte classification
module jsv_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_data,
    input  logic           in_last,
    output logic           out_valid,
    input  logic           out_ready,
    output jsv_pkg::word_t out_word
);

    logic [3:0] utf8_reg, utf8_next;
    logic       bad;
    logic [7:0] lo, hi;
    logic       accept;

    assign in_ready = out_ready;
    assign out_valid = in_valid;
    assign accept = in_valid && out_ready;

    always_comb begin
        utf8_next = utf8_reg;
        bad = 1'b0;
        lo = 8'h80;
        hi = 8'hBF;
        case (utf8_reg)
            4'd0: begin
                if (in_data == 8'h00) bad = 1'b1;
                else if (in_data < 8'h80) utf8_next = 4'd0;
                else if (in_data >= 8'hC2 && in_data <= 8'hDF) utf8_next = 4'd1;
                else if (in_data == 8'hE0) utf8_next = 4'd3;
                else if (in_data == 8'hED) utf8_next = 4'd4;
                else if (in_data >= 8'hE1 && in_data <= 8'hEF) utf8_next = 4'd2;
                else if (in_data == 8'hF0) utf8_next = 4'd6;
                else if (in_data == 8'hF4) utf8_next = 4'd7;
                else if (in_data >= 8'hF1 && in_data <= 8'hF3) utf8_next = 4'd5;
                else bad = 1'b1;
            end
            4'd1, 4'd2, 4'd5: ;
            4'd3: lo = 8'hA0;
            4'd4: hi = 8'h9F;
            4'd6: lo = 8'h90;
            4'd7: hi = 8'h8F;
            default: bad = 1'b1;
        endcase
        if (utf8_reg != 4'd0 && !bad) begin
            if (in_data < lo || in_data > hi) bad = 1'b1;
            else if (utf8_reg == 4'd1) utf8_next = 4'd0;
            else if (utf8_reg <= 4'd4) utf8_next = 4'd1;
            else utf8_next = 4'd2;
        end
    end

    // state after a failing byte does not matter: error is sticky downstream
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utf8_reg <= 4'd0;
        end else if (accept) begin
            utf8_reg <= in_last ? 4'd0 : utf8_next;
        end
    end

    always_comb begin
        out_word.data = in_data;
        out_word.last = in_last;
        out_word.utf8_bad = bad;
        out_word.utf8_open = !bad && utf8_next != 4'd0;
        out_word.is_ws = in_data == 8'h20 || in_data == 8'h09 ||
            in_data == 8'h0A || in_data == 8'h0D;
        out_word.is_digit = in_data >= "0" && in_data <= "9";
        out_word.is_hex = (in_data >= "0" && in_data <= "9") ||
            (in_data >= "a" && in_data <= "f") || (in_data >= "A" && in_data <= "F");
    end

endmodule

/* hdl/jsv_queue.sv */
// short word queue between front and back
module jsv_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  jsv_pkg::word_t in_word,
    output logic           out_valid,
    input  logic           out_ready,
    output jsv_pkg::word_t out_word
);

    jsv_pkg::word_t mem_reg [jsv_pkg::QUEUE_DEPTH];
    logic [jsv_pkg::QUEUE_AW-1:0] wp_reg, rp_reg;
    logic [jsv_pkg::QUEUE_AW:0]   cnt_reg;
    logic push, pop;

    assign in_ready = cnt_reg != (jsv_pkg::QUEUE_AW+1)'(jsv_pkg::QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_word = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* hdl/jsv_back.sv */
// back end: pushdown json parser and result register
module jsv_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  jsv_pkg::word_t in_word,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           out_ok
);

    jsv_pkg::parse_state_t ps_reg, ps_next, ps_mid;
    logic [jsv_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic [2:0] sub_reg, sub_next;
    jsv_pkg::lit_kind_t kind_reg, kind_next;
    logic err_reg, err_next;
    logic stack_reg [jsv_pkg::MAX_NESTING];
    logic top_reg, top_next;
    logic push_en, push_bit;
    logic ovalid_reg, ok_reg;
    logic bad, fin, accept;
    logic [7:0] c;

    // only a last word has to wait for the result register
    assign in_ready = !ovalid_reg || out_ready || !in_word.last;
    assign accept = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign out_ok = ok_reg;
    assign c = in_word.data;

    // top of stack is held in a register, the array is written on push
    always_comb begin
        ps_mid = ps_reg;
        ps_next = ps_reg;
        depth_next = depth_reg;
        sub_next = sub_reg;
        kind_next = kind_reg;
        top_next = top_reg;
        push_en = 1'b0;
        push_bit = 1'b0;
        bad = 1'b0;
        fin = 1'b0;
        case (ps_reg)
            jsv_pkg::S_N_MINUS: begin
                fin = 1'b1;
                if (c == "0") ps_next = jsv_pkg::S_N_ZERO;
                else if (in_word.is_digit) ps_next = jsv_pkg::S_N_INT;
                else bad = 1'b1;
            end
            jsv_pkg::S_N_ZERO, jsv_pkg::S_N_INT: begin
                fin = 1'b1;
                if (ps_reg == jsv_pkg::S_N_INT && in_word.is_digit) ;
                else if (c == ".") ps_next = jsv_pkg::S_N_DOT;
                else if (c == "e" || c == "E") ps_next = jsv_pkg::S_N_EXP;
                else begin fin = 1'b0; ps_mid = jsv_pkg::S_AFTER; end
            end
            jsv_pkg::S_N_DOT: begin
                fin = 1'b1;
                if (in_word.is_digit) ps_next = jsv_pkg::S_N_FRAC;
                else bad = 1'b1;
            end
            jsv_pkg::S_N_FRAC: begin
                fin = 1'b1;
                if (in_word.is_digit) ;
                else if (c == "e" || c == "E") ps_next = jsv_pkg::S_N_EXP;
                else begin fin = 1'b0; ps_mid = jsv_pkg::S_AFTER; end
            end
            jsv_pkg::S_N_EXP: begin
                fin = 1'b1;
                if (c == "+" || c == "-") ps_next = jsv_pkg::S_N_ESIGN;
                else if (in_word.is_digit) ps_next = jsv_pkg::S_N_EDIG;
                else bad = 1'b1;
            end
            jsv_pkg::S_N_ESIGN: begin
                fin = 1'b1;
                if (in_word.is_digit) ps_next = jsv_pkg::S_N_EDIG;
                else bad = 1'b1;
            end
            jsv_pkg::S_N_EDIG: begin
                fin = 1'b1;
                if (!in_word.is_digit) begin fin = 1'b0; ps_mid = jsv_pkg::S_AFTER; end
            end
            default: ;
        endcase

        if (!fin) begin
            ps_next = ps_mid;
            case (ps_mid)
                jsv_pkg::S_VALUE, jsv_pkg::S_VAL_OR_CLOSE, jsv_pkg::S_KEY_OR_CLOSE,
                jsv_pkg::S_KEY, jsv_pkg::S_COLON, jsv_pkg::S_AFTER: begin
                    if (in_word.is_ws) ;
                    else if ((ps_mid == jsv_pkg::S_VAL_OR_CLOSE || ps_mid == jsv_pkg::S_AFTER)
                             && c == "]") begin
                        if (depth_reg == '0 || top_reg) bad = 1'b1;
                        else begin
                            depth_next = depth_reg - 1'b1;
                            ps_next = jsv_pkg::S_AFTER;
                        end
                    end else if ((ps_mid == jsv_pkg::S_KEY_OR_CLOSE || ps_mid == jsv_pkg::S_AFTER)
                                 && c == "}") begin
                        if (depth_reg == '0 || !top_reg) bad = 1'b1;
                        else begin
                            depth_next = depth_reg - 1'b1;
                            ps_next = jsv_pkg::S_AFTER;
                        end
                    end else if (ps_mid == jsv_pkg::S_KEY_OR_CLOSE || ps_mid == jsv_pkg::S_KEY) begin
                        if (c == "\"") ps_next = jsv_pkg::S_STR_KEY;
                        else bad = 1'b1;
                    end else if (ps_mid == jsv_pkg::S_COLON) begin
                        if (c == ":") ps_next = jsv_pkg::S_VALUE;
                        else bad = 1'b1;
                    end else if (ps_mid == jsv_pkg::S_AFTER) begin
                        if (c == "," && depth_reg != '0)
                            ps_next = top_reg ? jsv_pkg::S_KEY : jsv_pkg::S_VALUE;
                        else bad = 1'b1;
                    end else begin
                        if (c == "{" || c == "[") begin
                            if (depth_reg >= jsv_pkg::DEPTH_W'(jsv_pkg::MAX_NESTING)) bad = 1'b1;
                            else begin
                                push_en = 1'b1;
                                push_bit = c == "{";
                                top_next = c == "{";
                                depth_next = depth_reg + 1'b1;
                                ps_next = (c == "{") ? jsv_pkg::S_KEY_OR_CLOSE
                                                     : jsv_pkg::S_VAL_OR_CLOSE;
                            end
                        end else if (c == "\"") ps_next = jsv_pkg::S_STR_VAL;
                        else if (c == "t" || c == "f" || c == "n") begin
                            kind_next = (c == "t") ? jsv_pkg::LIT_TRUE :
                                        (c == "f") ? jsv_pkg::LIT_FALSE : jsv_pkg::LIT_NULL;
                            sub_next = 3'd1;
                            ps_next = jsv_pkg::S_LIT;
                        end else if (c == "-") ps_next = jsv_pkg::S_N_MINUS;
                        else if (c == "0") ps_next = jsv_pkg::S_N_ZERO;
                        else if (in_word.is_digit) ps_next = jsv_pkg::S_N_INT;
                        else bad = 1'b1;
                    end
                end
                jsv_pkg::S_STR_VAL, jsv_pkg::S_STR_KEY: begin
                    if (c == "\"")
                        ps_next = (ps_mid == jsv_pkg::S_STR_KEY) ? jsv_pkg::S_COLON
                                                                 : jsv_pkg::S_AFTER;
                    else if (c == "\\")
                        ps_next = (ps_mid == jsv_pkg::S_STR_KEY) ? jsv_pkg::S_ESC_KEY
                                                                 : jsv_pkg::S_ESC_VAL;
                    else if (c < 8'h20) bad = 1'b1;
                end
                jsv_pkg::S_ESC_VAL, jsv_pkg::S_ESC_KEY: begin
                    if (c == "u") begin
                        sub_next = 3'd0;
                        ps_next = (ps_mid == jsv_pkg::S_ESC_KEY) ? jsv_pkg::S_HEX_KEY
                                                                 : jsv_pkg::S_HEX_VAL;
                    end else if (c == "\"" || c == "\\" || c == "/" || c == "b" ||
                                 c == "f" || c == "n" || c == "r" || c == "t")
                        ps_next = (ps_mid == jsv_pkg::S_ESC_KEY) ? jsv_pkg::S_STR_KEY
                                                                 : jsv_pkg::S_STR_VAL;
                    else bad = 1'b1;
                end
                jsv_pkg::S_HEX_VAL, jsv_pkg::S_HEX_KEY: begin
                    if (!in_word.is_hex) bad = 1'b1;
                    else begin
                        sub_next = sub_reg + 3'd1;
                        if (sub_reg >= 3'd3)
                            ps_next = (ps_mid == jsv_pkg::S_HEX_KEY) ? jsv_pkg::S_STR_KEY
                                                                     : jsv_pkg::S_STR_VAL;
                    end
                end
                jsv_pkg::S_LIT: begin
                    if (kind_reg == jsv_pkg::LIT_NONE || sub_reg >= jsv_pkg::lit_len(kind_reg)
                        || c != jsv_pkg::lit_char(kind_reg, sub_reg)) bad = 1'b1;
                    else begin
                        sub_next = sub_reg + 3'd1;
                        if (sub_reg + 3'd1 == jsv_pkg::lit_len(kind_reg))
                            ps_next = jsv_pkg::S_AFTER;
                    end
                end
                default: bad = 1'b1;
            endcase
        end
        err_next = err_reg || bad || in_word.utf8_bad;
    end

    // array read for the new top after a pop
    logic [jsv_pkg::STACK_AW-1:0] pop_idx;
    logic pop_en;
    assign pop_en = depth_next < depth_reg && depth_next != '0;
    assign pop_idx = jsv_pkg::STACK_AW'(depth_next - 1'b1);

    always_ff @(posedge aclk) begin
        if (accept && !err_reg && push_en)
            stack_reg[jsv_pkg::STACK_AW'(depth_reg)] <= push_bit;
        if (accept && !err_reg && pop_en)
            top_reg <= stack_reg[pop_idx];
        else if (accept && !err_reg)
            top_reg <= top_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps_reg <= jsv_pkg::S_VALUE;
            depth_reg <= '0;
            sub_reg <= '0;
            kind_reg <= jsv_pkg::LIT_TRUE;
            err_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            ok_reg <= 1'b0;
        end else begin
            if (out_valid && out_ready) ovalid_reg <= 1'b0;
            if (accept) begin
                if (in_word.last) begin
                    ovalid_reg <= 1'b1;
                    ok_reg <= !err_next && !in_word.utf8_open && depth_next == '0 &&
                        (ps_next == jsv_pkg::S_AFTER || ps_next == jsv_pkg::S_N_ZERO ||
                         ps_next == jsv_pkg::S_N_INT || ps_next == jsv_pkg::S_N_FRAC ||
                         ps_next == jsv_pkg::S_N_EDIG);
                    ps_reg <= jsv_pkg::S_VALUE;
                    depth_reg <= '0;
                    sub_reg <= '0;
                    kind_reg <= jsv_pkg::LIT_TRUE;
                    err_reg <= 1'b0;
                end else if (!err_reg) begin
                    ps_reg <= ps_next;
                    depth_reg <= depth_next;
                    sub_reg <= sub_next;
                    kind_reg <= kind_next;
                    err_reg <= err_next;
                end
            end
        end
    end

endmodule

/* hdl/json_syntax_validator.sv */
// top level of the streaming json syntax validator
// Takes one byte per cycle, with s_last_byte on the final byte of a text, as long as no
// result waits on m_ready; the last byte is registered in the four-word queue, then the
// parser registers the json_ok word in its result register. A result waiting on m_ready
// holds back the next last byte in the parser, and the bytes behind it once the queue is
// full. The parser's pushdown step and stack write set the one-byte-per-cycle figure.
// Nesting beyond 64 levels counts as invalid. No clearing pass is needed after reset.
module json_syntax_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_json_ok
);

    jsv_pkg::word_t f_word, q_word;
    logic f_valid, f_ready, q_valid, q_ready;

    jsv_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_data(s_data_byte), .in_last(s_last_byte),
        .out_valid(f_valid), .out_ready(f_ready), .out_word(f_word)
    );

    jsv_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
        .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word)
    );

    jsv_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_word(q_word),
        .out_valid(m_valid), .out_ready(m_ready), .out_ok(m_json_ok)
    );

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_json_ok))
        else $error("result dropped while stalled");

    a_front_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == f_ready)
        else $error("front ready mismatch");

    a_ok_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !$isunknown(m_json_ok))
        else $error("unknown result word");

endmodule

/* bench/json_syntax_validator_tb.sv */
`timescale 1ns / 100ps
// testbench for the streaming json syntax validator with utf-8 checking
module json_syntax_validator_tb;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_last_byte;
    logic       m_valid;
    logic       m_ready;
    logic       m_json_ok;

    json_syntax_validator i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data_byte(s_data_byte),
        .s_last_byte(s_last_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_json_ok  (m_json_ok)
    );

    // predictor state
    logic [3:0]            u8_st;
    jsv_pkg::parse_state_t ps;
    logic                  nest_stack [jsv_pkg::MAX_NESTING];
    int                    nest_cnt;
    logic [2:0]            lit_pos;
    jsv_pkg::lit_kind_t    lit_sel;
    logic                  sticky_err;

    logic         verdict_q [$];
    int           n_bytes;
    int           n_texts;
    int           n_valid;
    int           n_checked;
    int           n_errors;
    int           burst_left;
    longint       cycle_cnt;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic bit is_ws_c(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_hexc(logic [7:0] c);
        return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [7:0] lit_ch(jsv_pkg::lit_kind_t k, logic [2:0] p);
        string s;
        if (k == jsv_pkg::LIT_TRUE) s = "true";
        else if (k == jsv_pkg::LIT_FALSE) s = "false";
        else s = "null";
        return (p < s.len()) ? s[p] : 8'h00;
    endfunction

    task automatic clear_predictor();
        u8_st = 4'd0;
        ps = jsv_pkg::S_VALUE;
        nest_cnt = 0;
        lit_pos = 3'd0;
        lit_sel = jsv_pkg::LIT_TRUE;
        sticky_err = 1'b0;
    endtask

    function automatic bit top_obj();
        if (nest_cnt == 0) return 1'b0;
        return nest_stack[nest_cnt-1];
    endfunction

    function automatic bit push_nest(bit obj);
        if (nest_cnt >= jsv_pkg::MAX_NESTING) return 1'b0;
        nest_stack[nest_cnt] = obj;
        nest_cnt++;
        ps = obj ? jsv_pkg::S_KEY_OR_CLOSE : jsv_pkg::S_VAL_OR_CLOSE;
        return 1'b1;
    endfunction

    function automatic bit pop_nest(bit obj);
        if (nest_cnt == 0 || top_obj() != obj) return 1'b0;
        nest_cnt--;
        ps = jsv_pkg::S_AFTER;
        return 1'b1;
    endfunction

    function automatic bit begin_value(logic [7:0] c);
        if (c == "{") return push_nest(1'b1);
        if (c == "[") return push_nest(1'b0);
        if (c == "\"") begin
            ps = jsv_pkg::S_STR_VAL;
            return 1'b1;
        end
        if (c == "t" || c == "f" || c == "n") begin
            lit_sel = (c == "t") ? jsv_pkg::LIT_TRUE :
                      (c == "f") ? jsv_pkg::LIT_FALSE : jsv_pkg::LIT_NULL;
            lit_pos = 3'd1;
            ps = jsv_pkg::S_LIT;
            return 1'b1;
        end
        if (c == "-") begin
            ps = jsv_pkg::S_N_MINUS;
            return 1'b1;
        end
        if (c == "0") begin
            ps = jsv_pkg::S_N_ZERO;
            return 1'b1;
        end
        if (c >= "1" && c <= "9") begin
            ps = jsv_pkg::S_N_INT;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit utf8_ok(logic [7:0] c);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        case (u8_st)
            4'd0: begin
                if (c == 8'h00) return 1'b0;
                if (c < 8'h80) return 1'b1;
                if (c >= 8'hC2 && c <= 8'hDF) begin u8_st = 4'd1; return 1'b1; end
                if (c == 8'hE0) begin u8_st = 4'd3; return 1'b1; end
                if (c == 8'hED) begin u8_st = 4'd4; return 1'b1; end
                if (c >= 8'hE1 && c <= 8'hEF) begin u8_st = 4'd2; return 1'b1; end
                if (c == 8'hF0) begin u8_st = 4'd6; return 1'b1; end
                if (c == 8'hF4) begin u8_st = 4'd7; return 1'b1; end
                if (c >= 8'hF1 && c <= 8'hF3) begin u8_st = 4'd5; return 1'b1; end
                return 1'b0;
            end
            4'd1, 4'd2, 4'd5: ;
            4'd3: lo = 8'hA0;
            4'd4: hi = 8'h9F;
            4'd6: lo = 8'h90;
            4'd7: hi = 8'h8F;
            default: return 1'b0;
        endcase
        if (c < lo || c > hi) return 1'b0;
        if (u8_st == 4'd1) u8_st = 4'd0;
        else if (u8_st <= 4'd4) u8_st = 4'd1;
        else u8_st = 4'd2;
        return 1'b1;
    endfunction

    function automatic bit syntax_ok(logic [7:0] c);
        case (ps)
            jsv_pkg::S_N_MINUS: begin
                if (c == "0") begin ps = jsv_pkg::S_N_ZERO; return 1'b1; end
                if (c >= "1" && c <= "9") begin ps = jsv_pkg::S_N_INT; return 1'b1; end
                return 1'b0;
            end
            jsv_pkg::S_N_ZERO, jsv_pkg::S_N_INT: begin
                if (ps == jsv_pkg::S_N_INT && is_dig(c)) return 1'b1;
                if (c == ".") begin ps = jsv_pkg::S_N_DOT; return 1'b1; end
                if (c == "e" || c == "E") begin ps = jsv_pkg::S_N_EXP; return 1'b1; end
                ps = jsv_pkg::S_AFTER;
            end
            jsv_pkg::S_N_DOT: begin
                if (is_dig(c)) begin ps = jsv_pkg::S_N_FRAC; return 1'b1; end
                return 1'b0;
            end
            jsv_pkg::S_N_FRAC: begin
                if (is_dig(c)) return 1'b1;
                if (c == "e" || c == "E") begin ps = jsv_pkg::S_N_EXP; return 1'b1; end
                ps = jsv_pkg::S_AFTER;
            end
            jsv_pkg::S_N_EXP: begin
                if (c == "+" || c == "-") begin ps = jsv_pkg::S_N_ESIGN; return 1'b1; end
                if (is_dig(c)) begin ps = jsv_pkg::S_N_EDIG; return 1'b1; end
                return 1'b0;
            end
            jsv_pkg::S_N_ESIGN: begin
                if (is_dig(c)) begin ps = jsv_pkg::S_N_EDIG; return 1'b1; end
                return 1'b0;
            end
            jsv_pkg::S_N_EDIG: begin
                if (is_dig(c)) return 1'b1;
                ps = jsv_pkg::S_AFTER;
            end
            default: ;
        endcase
        case (ps)
            jsv_pkg::S_VALUE: return is_ws_c(c) || begin_value(c);
            jsv_pkg::S_VAL_OR_CLOSE: begin
                if (is_ws_c(c)) return 1'b1;
                if (c == "]") return pop_nest(1'b0);
                return begin_value(c);
            end
            jsv_pkg::S_KEY_OR_CLOSE, jsv_pkg::S_KEY: begin
                if (is_ws_c(c)) return 1'b1;
                if (c == "}" && ps == jsv_pkg::S_KEY_OR_CLOSE) return pop_nest(1'b1);
                if (c == "\"") begin ps = jsv_pkg::S_STR_KEY; return 1'b1; end
                return 1'b0;
            end
            jsv_pkg::S_COLON: begin
                if (is_ws_c(c)) return 1'b1;
                if (c == ":") begin ps = jsv_pkg::S_VALUE; return 1'b1; end
                return 1'b0;
            end
            jsv_pkg::S_AFTER: begin
                if (is_ws_c(c)) return 1'b1;
                if (c == "," && nest_cnt > 0) begin
                    ps = top_obj() ? jsv_pkg::S_KEY : jsv_pkg::S_VALUE;
                    return 1'b1;
                end
                if (c == "]") return pop_nest(1'b0);
                if (c == "}") return pop_nest(1'b1);
                return 1'b0;
            end
            jsv_pkg::S_STR_VAL, jsv_pkg::S_STR_KEY: begin
                if (c == "\"") begin
                    ps = (ps == jsv_pkg::S_STR_KEY) ? jsv_pkg::S_COLON : jsv_pkg::S_AFTER;
                    return 1'b1;
                end
                if (c == "\\") begin
                    ps = (ps == jsv_pkg::S_STR_KEY) ? jsv_pkg::S_ESC_KEY : jsv_pkg::S_ESC_VAL;
                    return 1'b1;
                end
                return c >= 8'h20;
            end
            jsv_pkg::S_ESC_VAL, jsv_pkg::S_ESC_KEY: begin
                if (c == "u") begin
                    lit_pos = 3'd0;
                    ps = (ps == jsv_pkg::S_ESC_KEY) ? jsv_pkg::S_HEX_KEY : jsv_pkg::S_HEX_VAL;
                    return 1'b1;
                end
                if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                    c == "n" || c == "r" || c == "t") begin
                    ps = (ps == jsv_pkg::S_ESC_KEY) ? jsv_pkg::S_STR_KEY : jsv_pkg::S_STR_VAL;
                    return 1'b1;
                end
                return 1'b0;
            end
            jsv_pkg::S_HEX_VAL, jsv_pkg::S_HEX_KEY: begin
                if (!is_hexc(c)) return 1'b0;
                lit_pos++;
                if (lit_pos >= 3'd4)
                    ps = (ps == jsv_pkg::S_HEX_KEY) ? jsv_pkg::S_STR_KEY : jsv_pkg::S_STR_VAL;
                return 1'b1;
            end
            jsv_pkg::S_LIT: begin
                if (lit_sel == jsv_pkg::LIT_NONE || lit_pos >= jsv_pkg::lit_len(lit_sel))
                    return 1'b0;
                if (c != lit_ch(lit_sel, lit_pos)) return 1'b0;
                lit_pos++;
                if (lit_pos == jsv_pkg::lit_len(lit_sel)) ps = jsv_pkg::S_AFTER;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // advance the predictor by one byte and queue the verdict on the last one
    task automatic predict_byte(logic [7:0] c, logic last);
        bit u;
        bit j;
        bit ok;
        if (!sticky_err) begin
            u = utf8_ok(c);
            j = syntax_ok(c);
            if (!u || !j) sticky_err = 1'b1;
        end
        if (last) begin
            ok = !sticky_err && u8_st == 4'd0 && nest_cnt == 0 &&
                 (ps == jsv_pkg::S_AFTER || ps == jsv_pkg::S_N_ZERO ||
                  ps == jsv_pkg::S_N_INT || ps == jsv_pkg::S_N_FRAC ||
                  ps == jsv_pkg::S_N_EDIG);
            verdict_q.push_back(ok);
            n_texts++;
            if (ok) n_valid++;
            clear_predictor();
        end
    endtask

    // send one byte, with bursts and gaps on the sender side
    task automatic send_byte(logic [7:0] c, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data_byte <= c;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_byte(c, last);
        n_bytes++;
        @(negedge aclk);
    endtask

    task automatic send_text(string t);
        for (int i = 0; i < t.len(); i++) send_byte(t[i], i == t.len() - 1);
    endtask

    task automatic send_raw(logic [7:0] bytes [$]);
        for (int i = 0; i < bytes.size(); i++) send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // receiver stall pattern and result checker
    always @(negedge aclk) begin
        if (aresetn) m_ready <= ((cycle_cnt % 23) < 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected word: json_ok actual %0b", m_json_ok);
                n_errors++;
            end else begin
                if (m_json_ok !== verdict_q[0]) begin
                    $error("json_ok mismatch: expected %0b actual %0b",
                           verdict_q[0], m_json_ok);
                    n_errors++;
                end
                void'(verdict_q.pop_front());
                n_checked++;
            end
        end
    end

    task automatic test_directed();
        logic [7:0] b [$];
        send_text("{\"a\":[1,-0.5e+3,true,false,null],\"b\":{}}");
        send_text(" \t\r\n\"x\\u00aF\\n\\\"\" ");
        send_text("123");
        send_text("1.");
        send_text("[1,2}");
        send_text("]");
        send_text("{} x");
        send_text("tru");
        send_text("01");
        send_text("{\"k\" 1}");
        send_text("[,]");
        b = '{8'h22, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h22};
        send_raw(b);
        b = '{8'h22, 8'hC0, 8'h80, 8'h22};
        send_raw(b);
        b = '{8'h22, 8'hED, 8'hA0, 8'h80, 8'h22};
        send_raw(b);
        b = '{8'h22, 8'hF4, 8'h90, 8'h80, 8'h80, 8'h22};
        send_raw(b);
        b = '{8'h22, 8'h00, 8'h22};
        send_raw(b);
        b = '{8'h22, 8'hE1, 8'h80};
        send_raw(b);
        b = '{8'hFF};
        send_raw(b);
        b = '{8'h22, 8'h1F, 8'h22};
        send_raw(b);
    endtask

    task automatic test_nesting_limit();
        string t;
        t = "";
        for (int i = 0; i < jsv_pkg::MAX_NESTING; i++) begin
            if (i % 2) t = {t, "{\"k\":"};
            else t = {t, "["};
        end
        for (int i = jsv_pkg::MAX_NESTING - 1; i >= 0; i--) begin
            if (i % 2) t = {t, "}"};
            else t = {t, "]"};
        end
        send_text(t);
        t = "";
        for (int i = 0; i <= jsv_pkg::MAX_NESTING; i++) t = {t, "["};
        for (int i = 0; i <= jsv_pkg::MAX_NESTING; i++) t = {t, "]"};
        send_text(t);
    endtask

    function automatic string rand_value(int lvl);
        string s;
        int n;
        case ($urandom_range(0, (lvl > 3) ? 4 : 6))
            0: begin
                if ($urandom_range(0, 1)) s = "true";
                else if ($urandom_range(0, 1)) s = "false";
                else s = "null";
                return s;
            end
            1: begin
                if ($urandom_range(0, 1)) s = "-";
                else s = "";
                s = {s, $sformatf("%0d", $urandom_range(0, 999))};
                if ($urandom_range(0, 1)) s = {s, ".", $sformatf("%0d", $urandom_range(0, 99))};
                if ($urandom_range(0, 2) == 0) s = {s, "E-", $sformatf("%0d", $urandom_range(0, 9))};
                return s;
            end
            2, 3: begin
                s = "\"";
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        0: s = {s, "\\u", $sformatf("%04x", $urandom_range(0, 65535))};
                        1: s = {s, "\\t"};
                        default: s = {s, string'(8'($urandom_range(8'h23, 8'h5B)))};
                    endcase
                end
                return {s, "\""};
            end
            4: return " 0 ";
            5: begin
                s = "[";
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) s = {s, ", "};
                    s = {s, rand_value(lvl + 1)};
                end
                return {s, "]"};
            end
            default: begin
                s = "{";
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) s = {s, ","};
                    s = {s, "\"k", $sformatf("%0d", i), "\": ", rand_value(lvl + 1)};
                end
                return {s, "}"};
            end
        endcase
    endfunction

    task automatic test_random_texts();
        string t;
        logic [7:0] b [$];
        int pos;
        while (n_bytes < 850) begin
            t = rand_value(0);
            b = {};
            for (int i = 0; i < t.len(); i++) b.push_back(t[i]);
            case ($urandom_range(0, 9))
                0: begin
                    pos = $urandom_range(0, b.size() - 1);
                    b[pos] = 8'($urandom);
                end
                1: if (b.size() > 1) void'(b.pop_back());
                2: begin
                    b = {};
                    repeat ($urandom_range(1, 8)) b.push_back(8'($urandom));
                end
                default: ;
            endcase
            send_raw(b);
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_byte = 8'h00;
        s_last_byte = 1'b0;
        m_ready = 1'b0;
        cycle_cnt = 0;
        n_bytes = 0;
        n_texts = 0;
        n_valid = 0;
        n_checked = 0;
        n_errors = 0;
        burst_left = 0;
        clear_predictor();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_nesting_limit();
        test_random_texts();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("%0d bytes in %0d texts, %0d valid; %0d verdicts checked",
                 n_bytes, n_texts, n_valid, n_checked);
        if (n_errors == 0) begin
            $display("json_syntax_validator_tb OK");
        end else begin
            $display("json_syntax_validator_tb NOT OK");
        end
        $finish;
    end

    initial begin
        wait (cycle_cnt > 200000);
        $display("json_syntax_validator_tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
hdl/jsv_pkg.sv
hdl/jsv_front.sv
hdl/jsv_queue.sv
hdl/jsv_back.sv
hdl/json_syntax_validator.sv
bench/json_syntax_validator_tb.sv
